[hw/rtl/abpf_pkg.sv]
// Shared types, constants and helpers for the alignment break pair finder.
// No dependencies; every other file of the block depends on this package.
package abpf_pkg;

	// Fixed field widths of the ports.
	localparam int MaxEntries = 16;
	localparam int MaskW      = 16;
	localparam int ColW       = 16;
	localparam int CountW     = 5;

	// Defaults for the top-level parameters.
	localparam int DefLiveBreaks = 16;
	localparam int DefColumnBits = 16;

	// Depth of the queue between the front and back parts (a power of two).
	localparam int QDepth = 2;
	localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
	localparam int QCntW  = $clog2(QDepth + 1);

	localparam logic [CountW-1:0] EntryCountReset = CountW'(16);

	typedef logic [MaskW-1:0] mask_t;
	typedef logic [ColW-1:0]  col_t;

	// One classified column as it travels from the front to the back part.
	typedef struct packed {
		mask_t cur;       // masked present mask of this column
		mask_t left;      // masked mask of the column before it
		col_t  col;       // column index, low bits
		logic  is_break;
		logic  start;     // first column of a new alignment
		logic  cnt_ovf;   // sticky counter saturation after this column
	} abpf_item_t;

	typedef enum logic {
		BS_IDLE,
		BS_EMIT
	} abpf_bstate_t;

	// Mask of the n entries in use; n above MaxEntries counts as MaxEntries.
	function automatic mask_t full_mask(input logic [CountW-1:0] n);
		if (n >= CountW'(MaxEntries)) begin
			return '1;
		end
		return mask_t'((32'd1 << n) - 32'd1);
	endfunction

endpackage

[hw/rtl/abpf_front.sv]
// Front part: accepts columns, keeps the column counter and the previous mask,
// and classifies each column as a break or not. Depends on abpf_pkg.
module abpf_front #(
	parameter int COLUMN_BITS = abpf_pkg::DefColumnBits
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  abpf_pkg::mask_t        present_mask,
	input  logic                   start_alignment,
	input  abpf_pkg::mask_t        full,
	input  logic                   q_full,
	output logic                   push,
	output abpf_pkg::abpf_item_t   push_item
);
	import abpf_pkg::*;

	localparam logic [COLUMN_BITS-1:0] ColMax = '1;

	logic [COLUMN_BITS-1:0] cnt_q, cnt_eff;
	mask_t                  prev_q, prev_eff, cur;
	logic                   have_q, have_eff, ovf_q, ovf_eff, at_top, ovf_next;
	col_t                   col_low;

	// A request is taken whenever the queue has room.
	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	// The start of a new alignment sees cleared state.
	always_comb begin
		cur      = present_mask & full;
		prev_eff = start_alignment ? '0 : prev_q;
		have_eff = start_alignment ? 1'b0 : have_q;
		cnt_eff  = start_alignment ? '0 : cnt_q;
		ovf_eff  = start_alignment ? 1'b0 : ovf_q;
		at_top   = (cnt_eff == ColMax);
		ovf_next = ovf_eff || at_top;
	end

	// Column index as seen on the result ports.
	generate
		if (COLUMN_BITS >= ColW) begin : g_col_trunc
			assign col_low = cnt_eff[ColW-1:0];
		end else begin : g_col_ext
			assign col_low = {{(ColW - COLUMN_BITS){1'b0}}, cnt_eff};
		end
	endgenerate

	// Classified column handed to the queue.
	always_comb begin
		push_item          = '0;
		push_item.cur      = cur;
		push_item.left     = prev_eff & full;
		push_item.col      = col_low;
		push_item.is_break = have_eff && ((prev_eff & full & cur) == '0);
		push_item.start    = start_alignment;
		push_item.cnt_ovf  = ovf_next;
	end

	// Column counter saturates at its top value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			prev_q <= '0;
			have_q <= 1'b0;
			ovf_q  <= 1'b0;
		end else if (push) begin
			cnt_q  <= at_top ? cnt_eff : cnt_eff + 1'b1;
			prev_q <= cur;
			have_q <= 1'b1;
			ovf_q  <= ovf_next;
		end
	end

endmodule

[hw/rtl/abpf_queue.sv]
// Short queue of classified columns between the front and back parts.
// Depends on abpf_pkg for the item type and depth.
module abpf_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  abpf_pkg::abpf_item_t push_item,
	input  logic                 pop,
	output logic                 full,
	output logic                 not_empty,
	output abpf_pkg::abpf_item_t head
);
	import abpf_pkg::*;

	abpf_item_t       mem_q [QDepth];
	logic [QPtrW-1:0] wr_q, rd_q;
	logic [QCntW-1:0] cnt_q;

	assign full      = (cnt_q == QCntW'(QDepth));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

endmodule

[hw/rtl/abpf_back.sv]
// Back part: holds the live break list, checks every live break against a new
// break, then emits the good pairs one per cycle while the receiver is ready. Depends on abpf_pkg.
module abpf_back #(
	parameter int LIVE_BREAKS = abpf_pkg::DefLiveBreaks
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  abpf_pkg::mask_t      full,
	input  logic                 q_valid,
	input  abpf_pkg::abpf_item_t head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output abpf_pkg::col_t       break_first,
	output abpf_pkg::col_t       break_second,
	output logic                 last_of_run,
	output logic                 overflowed
);
	import abpf_pkg::*;

	localparam int SlotW = (LIVE_BREAKS > 1) ? $clog2(LIVE_BREAKS) : 1;

	// Live break list.
	col_t                   col_q  [LIVE_BREAKS];
	mask_t                  left_q [LIVE_BREAKS];
	mask_t                  mid_q  [LIVE_BREAKS];
	logic [LIVE_BREAKS-1:0] valid_q;
	logic                   list_ovf_q;

	// Break under way.
	logic [LIVE_BREAKS-1:0] good_q;
	col_t                   s_col_q;
	mask_t                  s_left_q, s_cur_q;
	logic [SlotW-1:0]       s_slot_q;
	logic                   s_store_q, s_cntovf_q;

	// Result register.
	logic                   out_valid_q, last_q, ovf_out_q;
	col_t                   first_q, second_q;

	abpf_bstate_t           state_q, state_d;

	logic [LIVE_BREAKS-1:0] vld_eff, lane_ok, lane_good, lane_never, valid_after;
	logic [SlotW-1:0]       free_slot, emit_idx;
	logic                   has_free, has_good, do_store, out_free, emit, emit_self;

	// Pair checks of every live break against the head column, lane by lane.
	always_comb begin
		vld_eff = head.start ? '0 : valid_q;
		for (int i = 0; i < LIVE_BREAKS; i++) begin
			lane_ok[i]    = ((left_q[i] & full & head.cur) == '0)
				&& (((left_q[i] & full) | head.cur) != full)
				&& ((left_q[i] & mid_q[i] & full) == '0);
			lane_good[i]  = vld_eff[i] && lane_ok[i] && ((mid_q[i] & full & head.cur) == '0);
			lane_never[i] = !lane_ok[i]
				|| ((((left_q[i] | mid_q[i]) & full) | head.cur) == full);
		end
		valid_after = head.is_break ? (vld_eff & ~lane_never) : vld_eff;
		do_store    = ((head.left | head.cur) != full);
	end

	// Lowest free slot once retired breaks are gone.
	always_comb begin
		has_free  = 1'b0;
		free_slot = '0;
		for (int i = LIVE_BREAKS - 1; i >= 0; i--) begin
			if (!valid_after[i]) begin
				has_free  = 1'b1;
				free_slot = SlotW'(i);
			end
		end
	end

	// Lowest pending good pair.
	always_comb begin
		has_good = 1'b0;
		emit_idx = '0;
		for (int i = LIVE_BREAKS - 1; i >= 0; i--) begin
			if (good_q[i]) begin
				has_good = 1'b1;
				emit_idx = SlotW'(i);
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BS_IDLE: begin
				if (q_valid && head.is_break) begin
					state_d = BS_EMIT;
				end
			end
			BS_EMIT: begin
				if (out_free && !has_good) begin
					state_d = BS_IDLE;
				end
			end
			default: state_d = BS_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		out_free  = !out_valid_q || out_ready;
		pop       = (state_q == BS_IDLE) && q_valid;
		emit      = (state_q == BS_EMIT) && out_free;
		emit_self = emit && !has_good;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BS_IDLE;
			valid_q     <= '0;
			good_q      <= '0;
			list_ovf_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				valid_q    <= valid_after;
				good_q     <= head.is_break ? (vld_eff & lane_good) : '0;
				list_ovf_q <= (list_ovf_q && !head.start)
					|| (head.is_break && do_store && !has_free);
			end else if (emit) begin
				if (has_good) begin
					good_q[emit_idx] <= 1'b0;
				end else if (s_store_q) begin
					valid_q[s_slot_q] <= 1'b1;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// List contents, the break under way and the result payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			for (int i = 0; i < LIVE_BREAKS; i++) begin
				if (valid_after[i]) begin
					mid_q[i] <= mid_q[i] | head.cur;
				end
			end
			s_col_q    <= head.col;
			s_left_q   <= head.left;
			s_cur_q    <= head.cur;
			s_slot_q   <= free_slot;
			s_store_q  <= head.is_break && do_store && has_free;
			s_cntovf_q <= head.cnt_ovf;
		end else if (emit_self && s_store_q) begin
			col_q[s_slot_q]  <= s_col_q;
			left_q[s_slot_q] <= s_left_q;
			mid_q[s_slot_q]  <= s_cur_q;
		end
		if (emit) begin
			first_q   <= has_good ? col_q[emit_idx] : s_col_q;
			second_q  <= s_col_q;
			last_q    <= !has_good;
			ovf_out_q <= s_cntovf_q || list_ovf_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign break_first  = first_q;
	assign break_second = second_q;
	assign last_of_run  = last_q;
	assign overflowed   = ovf_out_q;

endmodule

[hw/rtl/alignment_break_pair_finder.sv]
// Alignment break pair finder, top level. An accepted column goes through the queue to
// the back part, which checks a break against the live list, then emits its good pairs
// and last the self pair from the result register, and pops no new column until then.
// Reset is asynchronous and active low; it clears the live list, counters and flags.
module alignment_break_pair_finder #(
	parameter int LIVE_BREAKS = abpf_pkg::DefLiveBreaks,
	parameter int COLUMN_BITS = abpf_pkg::DefColumnBits
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [abpf_pkg::CountW-1:0]   cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  abpf_pkg::mask_t               present_mask,
	input  logic                          start_alignment,
	output logic                          out_valid,
	input  logic                          out_ready,
	output abpf_pkg::col_t                break_first,
	output abpf_pkg::col_t                break_second,
	output logic                          last_of_run,
	output logic                          overflowed
);
	import abpf_pkg::*;

	logic [CountW-1:0] entry_count_q;
	mask_t             full;
	logic              push, pop, q_full, q_valid;
	abpf_item_t        push_item, head;

	// Entry count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= EntryCountReset;
		end else if (cfg_we) begin
			entry_count_q <= cfg_wdata;
		end
	end

	assign full = full_mask(entry_count_q);

	abpf_front #(
		.COLUMN_BITS (COLUMN_BITS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.present_mask    (present_mask),
		.start_alignment (start_alignment),
		.full            (full),
		.q_full          (q_full),
		.push            (push),
		.push_item       (push_item)
	);

	abpf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_valid),
		.head      (head)
	);

	abpf_back #(
		.LIVE_BREAKS (LIVE_BREAKS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.full         (full),
		.q_valid      (q_valid),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.break_first  (break_first),
		.break_second (break_second),
		.last_of_run  (last_of_run),
		.overflowed   (overflowed)
	);

endmodule

[hw/rtl/abpf_checker.sv]
// Port-level checks for the alignment break pair finder, bound to the top level.
// Depends on abpf_pkg for the column type.
module abpf_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           out_valid,
	input logic           out_ready,
	input abpf_pkg::col_t break_first,
	input abpf_pkg::col_t break_second,
	input logic           last_of_run,
	input logic           overflowed
);

	// A stalled result holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(break_first)
			&& $stable(break_second) && $stable(last_of_run) && $stable(overflowed))
		else $error("result changed while stalled");

	// The final pair of a run is the new break paired with itself.
	a_self_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_run |-> break_first == break_second)
		else $error("final pair is not a self pair");

	// Pairs of one run follow each other without a gap.
	a_run_dense: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid)
		else $error("gap inside a run of pairs");

endmodule

bind alignment_break_pair_finder abpf_checker u_abpf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.break_first  (break_first),
	.break_second (break_second),
	.last_of_run  (last_of_run),
	.overflowed   (overflowed)
);

[verif/testbench.sv]
// Self-checking testbench for alignment_break_pair_finder: a local predictor of breaks and pairs
// checks every result, with random idling on both handshakes. Depends only on abpf_pkg and the
// top-level RTL.
`timescale 1ns / 1ps

module testbench;
	import abpf_pkg::*;

	localparam int LiveSlots = 16;
	localparam int DrainCycles = 64;
	localparam int CycleLimit = 100_000;

	// One expected result: a pair of break columns and its flags.
	typedef struct packed {
		col_t earlier;
		col_t later;
		logic last;
		logic ovf;
	} break_pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CountW-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	mask_t present_mask = '0;
	logic start_alignment = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	col_t break_first;
	col_t break_second;
	logic last_of_run;
	logic overflowed;

	// Predictor state.
	logic [CountW-1:0] entry_cnt = EntryCountReset;
	mask_t prev_mask = '0;
	logic have_prev = 1'b0;
	col_t col_ctr = '0;
	col_t live_col[LiveSlots];
	mask_t live_left[LiveSlots];
	mask_t live_mid[LiveSlots];
	logic live_on[LiveSlots] = '{default: 1'b0};
	logic ovf_sticky = 1'b0;

	break_pair_t pending_pairs[$];
	int errors = 0;
	int unsigned cycles = 0;

	// Sender and receiver pacing.
	logic gaps_enabled = 1'b1;
	int burst_left = 0;
	logic long_hold_req = 1'b0;
	int hold_left = 0;
	int ready_mode = 0;
	int ready_mode_left = 0;

	alignment_break_pair_finder uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.present_mask(present_mask),
		.start_alignment(start_alignment),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.break_first(break_first),
		.break_second(break_second),
		.last_of_run(last_of_run),
		.overflowed(overflowed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Works out the pairs that one accepted column yields and queues them.
	task automatic predict_column(input mask_t raw, input logic restart);
		mask_t full, cur, left_new, l, m;
		col_t idx;
		logic brk, good, never, stored;
		break_pair_t found[$];
		full = (entry_cnt >= CountW'(16)) ? '1 : mask_t'((17'd1 << entry_cnt) - 17'd1);
		cur = raw & full;
		if (restart) begin
			prev_mask = '0;
			have_prev = 1'b0;
			col_ctr = '0;
			ovf_sticky = 1'b0;
			for (int i = 0; i < LiveSlots; i++) live_on[i] = 1'b0;
		end
		idx = col_ctr;
		if (col_ctr == '1) begin
			ovf_sticky = 1'b1;
		end else begin
			col_ctr = col_ctr + 1'b1;
		end
		brk = have_prev && ((prev_mask & full & cur) == '0);
		if (brk) begin
			left_new = prev_mask & full;
			// Walk the live breaks in slot order against the new one.
			for (int i = 0; i < LiveSlots; i++) begin
				if (live_on[i]) begin
					l = live_left[i] & full;
					m = live_mid[i] & full;
					good = 1'b0;
					never = 1'b1;
					if ((l & cur) == '0 && (l | cur) != full && (l & m) == '0) begin
						good = ((m & cur) == '0);
						never = ((l | m | cur) == full);
					end
					if (good) found.push_back('{live_col[i], idx, 1'b0, 1'b0});
					if (never) begin
						live_on[i] = 1'b0;
					end else begin
						live_mid[i] = live_mid[i] | cur;
					end
				end
			end
			// The self pair always closes the run.
			found.push_back('{idx, idx, 1'b1, 1'b0});
			if ((left_new | cur) != full) begin
				stored = 1'b0;
				for (int i = 0; i < LiveSlots; i++) begin
					if (!stored && !live_on[i]) begin
						live_on[i] = 1'b1;
						live_col[i] = idx;
						live_left[i] = left_new;
						live_mid[i] = cur;
						stored = 1'b1;
					end
				end
				if (!stored) ovf_sticky = 1'b1;
			end
		end else begin
			for (int i = 0; i < LiveSlots; i++)
				if (live_on[i]) live_mid[i] = live_mid[i] | cur;
		end
		prev_mask = cur;
		have_prev = 1'b1;
		foreach (found[k]) begin
			found[k].ovf = ovf_sticky;
			pending_pairs.push_back(found[k]);
		end
	endtask

	// Offers one column request, with random gaps between bursts, and predicts on acceptance.
	task automatic send_column(input mask_t m, input logic restart);
		int gap;
		if (gaps_enabled && burst_left <= 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 25) : $urandom_range(0, 4);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		present_mask <= m;
		start_alignment <= restart;
		do @(posedge clk); while (!in_ready);
		predict_column(m, restart);
	endtask

	// Lets every expected pair arrive, then gives columns without results time to leave.
	task automatic drain_block();
		in_valid <= 1'b0;
		while (pending_pairs.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic set_entry_count(input logic [CountW-1:0] n);
		drain_block();
		cfg_we <= 1'b1;
		cfg_wdata <= n;
		entry_cnt = n;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// The first column after reset counts as column zero without a start flag.
	task automatic test_first_column_after_reset();
		send_column(16'hFFFF, 1'b0);
		send_column(16'h0000, 1'b0);
		send_column(16'h0003, 1'b0);
		send_column(16'h000C, 1'b0);
	endtask

	// Zero entries make every later column a break; counts above the maximum act as the maximum.
	task automatic test_entry_count_extremes();
		set_entry_count(5'd0);
		send_column(16'hFFFF, 1'b1);
		send_column(16'hFFFF, 1'b0);
		send_column(16'h1234, 1'b0);
		set_entry_count(5'd31);
		send_column(16'h8000, 1'b1);
		send_column(16'h7FFF, 1'b0);
		set_entry_count(5'd1);
		send_column(16'h0001, 1'b1);
		send_column(16'hFFFE, 1'b0);
	endtask

	// Empty columns keep every break alive, so the list fills and the last break gives the
	// longest run of pairs. The receiver holds off meanwhile so that the input stalls.
	task automatic test_full_break_list();
		set_entry_count(5'd16);
		long_hold_req = 1'b1;
		gaps_enabled = 1'b0;
		send_column(16'h0000, 1'b1);
		repeat (17) send_column(16'h0000, 1'b0);
		gaps_enabled = 1'b1;
	endtask

	// A new entry count applies to the masks of an alignment already under way.
	task automatic test_entry_count_mid_alignment();
		set_entry_count(5'd16);
		send_column(16'h0101, 1'b1);
		send_column(16'h0202, 1'b0);
		set_entry_count(5'd4);
		send_column(16'h0110, 1'b0);
		send_column(16'h0004, 1'b0);
	endtask

	// Sparse random masks give frequent breaks and long live lists; a few dense ones add noise.
	task automatic test_random_columns();
		logic [CountW-1:0] counts[4] = '{5'd2, 5'd5, 5'd8, 5'd16};
		mask_t m;
		logic restart;
		for (int phase = 0; phase < 4; phase++) begin
			set_entry_count(counts[phase]);
			for (int k = 0; k < 22; k++) begin
				case ($urandom_range(0, 9))
					0: begin
						m = '0;
					end
					1: begin
						m = mask_t'($urandom);
					end
					default: begin
						m = mask_t'($urandom & $urandom & $urandom);
					end
				endcase
				restart = (k == 0 && $urandom_range(0, 1) == 1) || ($urandom_range(0, 29) == 0);
				send_column(m, restart);
			end
		end
	endtask

	// Receiver: stretches of steady, light and heavy stalling, plus one long hold on request.
	always @(posedge clk) begin
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			if (ready_mode_left <= 0) begin
				ready_mode = $urandom_range(0, 2);
				ready_mode_left = $urandom_range(16, 80);
			end
			ready_mode_left--;
			case (ready_mode)
				0: begin
					out_ready <= 1'b1;
				end
				1: begin
					out_ready <= ($urandom_range(0, 3) != 0);
				end
				default: begin
					out_ready <= ($urandom_range(0, 3) == 0);
				end
			endcase
		end
	end

	// Compares each accepted pair with the oldest expected one.
	always @(posedge clk) begin : check_pairs
		break_pair_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pairs.size() == 0) begin
				$error("unexpected pair: break_first %0d, break_second %0d", break_first,
				       break_second);
				errors++;
			end else begin
				want = pending_pairs.pop_front();
				if (break_first !== want.earlier) begin
					$error("break_first: expected %0d, got %0d", want.earlier, break_first);
					errors++;
				end
				if (break_second !== want.later) begin
					$error("break_second: expected %0d, got %0d", want.later, break_second);
					errors++;
				end
				if (last_of_run !== want.last) begin
					$error("last_of_run: expected %0d, got %0d", want.last, last_of_run);
					errors++;
				end
				if (overflowed !== want.ovf) begin
					$error("overflowed: expected %0d, got %0d", want.ovf, overflowed);
					errors++;
				end
			end
		end
	end

	// Timeout guard.
	initial begin
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_first_column_after_reset();
		test_entry_count_extremes();
		test_full_break_list();
		test_entry_count_mid_alignment();
		test_random_columns();
		drain_block();
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

[files.f]
hw/rtl/abpf_pkg.sv
hw/rtl/abpf_front.sv
hw/rtl/abpf_queue.sv
hw/rtl/abpf_back.sv
hw/rtl/alignment_break_pair_finder.sv
hw/rtl/abpf_checker.sv
verif/testbench.sv
